>>> rtl/rdc_pkg.sv
package rdc_pkg;

	localparam int VALUE_W     = 32;
	localparam int RADIX_W     = 6;
	localparam int DIGIT_W     = 6;
	localparam int STACK_DEPTH = 32;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DIV_CNT_W   = $clog2(VALUE_W);

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

	// Item classes decided by the front end.
	typedef enum logic [1:0] {
		KIND_CONV = 2'b00,
		KIND_ZERO = 2'b01,
		KIND_BAD  = 2'b10
	} kind_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RADIX_W-1:0] radix;
		kind_t              kind;
	} item_t;

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] dividend;
		logic [RADIX_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] quot;
		logic [RADIX_W-1:0] rem;
	} div_rsp_t;

endpackage

>>> rtl/radix_digit_converter.sv
// Converts a 32-bit unsigned value to its digits in a radix from 2 to 36 and
// sends them out most significant first, one transaction per digit, with last
// set on the final one. A zero value produces no transaction at all. A radix
// outside 2..36 produces a single transaction with digit 0, last 1 and
// bad_radix 1. The front end classifies each input transaction and holds up
// to two in a queue, so new input is taken while a conversion runs. The back
// end divides by the radix with a bit-serial divider, one division per digit;
// the next division starts in the cycle the previous one reports done. Each
// digit is then popped from the digit stack through a stack read state and an
// emit state, and the emit state waits while the output is stalled. The
// result sits in an output register, so the back end prepares the next digit
// while the current one waits on out_stall.
module radix_digit_converter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [31:0]                 value,
	input  logic [5:0]                  radix,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [5:0]                  digit,
	output logic                        last,
	output logic                        bad_radix
);

	// Queue hand-off between the classifier and the conversion sequencer.
	logic              item_valid;
	rdc_pkg::item_t    item;
	logic              item_take;

	// Divider request and response.
	rdc_pkg::div_req_t div_req;
	rdc_pkg::div_rsp_t div_rsp;

	// Accept and classify; stall only when the queue is full.
	rdc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (rdc_pkg::VALUE_W'(value)),
		.radix      (rdc_pkg::RADIX_W'(radix)),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	// Single bit-serial divider, reused for every digit: one remainder digit per run.
	rdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequence divisions, push remainders, pop and emit the digits.
	rdc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit      (digit),
		.last       (last),
		.bad_radix  (bad_radix)
	);

endmodule

>>> rtl/rdc_front.sv
module rdc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [rdc_pkg::VALUE_W-1:0] value,
	input  logic [rdc_pkg::RADIX_W-1:0] radix,
	output logic                       item_valid,
	output rdc_pkg::item_t             item,
	input  logic                       item_take
);

	// Two-entry queue between classification and the back end.
	rdc_pkg::item_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           push;
	logic           pop;
	rdc_pkg::item_t cls;

	always_comb begin
		cls.value = value;
		cls.radix = radix;
		if (!(radix inside {[rdc_pkg::RADIX_MIN:rdc_pkg::RADIX_MAX]}))
			cls.kind = rdc_pkg::KIND_BAD;
		else if (value == '0)
			cls.kind = rdc_pkg::KIND_ZERO;
		else
			cls.kind = rdc_pkg::KIND_CONV;
	end

	assign in_stall   = (fill_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign item_valid = (fill_q != 2'd0);
	assign item       = ent_q[rd_ptr_q];
	assign pop        = item_valid && item_take;

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> rtl/rdc_div.sv
module rdc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rdc_pkg::div_req_t req,
	output rdc_pkg::div_rsp_t rsp
);

	// Restoring division, one quotient bit per cycle.
	logic [rdc_pkg::VALUE_W-1:0]   quo_q;
	logic [rdc_pkg::RADIX_W-1:0]   rem_q;
	logic [rdc_pkg::RADIX_W-1:0]   dvs_q;
	logic [rdc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [rdc_pkg::RADIX_W:0]     trial;
	logic [rdc_pkg::RADIX_W:0]     diff;
	logic                          qbit;

	assign trial = {rem_q, quo_q[rdc_pkg::VALUE_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[rdc_pkg::VALUE_W-2:0], qbit};
			rem_q <= qbit ? diff[rdc_pkg::RADIX_W-1:0] : trial[rdc_pkg::RADIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= rdc_pkg::DIV_CNT_W'(rdc_pkg::VALUE_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

>>> rtl/rdc_back.sv
module rdc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  rdc_pkg::item_t              item,
	output logic                        item_take,
	output rdc_pkg::div_req_t           div_req,
	input  rdc_pkg::div_rsp_t           div_rsp,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rdc_pkg::DIGIT_W-1:0] digit,
	output logic                        last,
	output logic                        bad_radix
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [rdc_pkg::CNT_W-1:0]     cnt_q;
	logic [rdc_pkg::RADIX_W-1:0]   radix_q;
	logic [rdc_pkg::DIGIT_W-1:0]   stack_mem [rdc_pkg::STACK_DEPTH];
	logic [rdc_pkg::DIGIT_W-1:0]   rd_q;
	logic [rdc_pkg::CNT_W-1:0]     top;
	logic                          push;
	logic                          slot_free;
	logic                          out_valid_q;
	logic [rdc_pkg::DIGIT_W-1:0]   digit_q;
	logic                          last_q;
	logic                          bad_q;
	logic                          load_bad;
	logic                          load_dig;

	assign slot_free = !out_valid_q || !out_stall;
	assign top       = cnt_q - 1'b1;

	assign item_take = (state_q == ST_IDLE) && item_valid &&
	                   ((item.kind != rdc_pkg::KIND_BAD) || slot_free);
	assign load_bad  = item_take && (item.kind == rdc_pkg::KIND_BAD);
	assign load_dig  = (state_q == ST_EMIT) && slot_free;
	assign push      = (state_q == ST_DIV) && div_rsp.done &&
	                   (cnt_q < rdc_pkg::CNT_W'(rdc_pkg::STACK_DEPTH));

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = div_rsp.quot;
		div_req.divisor  = radix_q;
		case (state_q)
			ST_IDLE: begin
				div_req.dividend = item.value;
				div_req.divisor  = item.radix;
				div_req.start    = item_take && (item.kind == rdc_pkg::KIND_CONV);
			end
			ST_DIV: begin
				div_req.start = div_rsp.done && (div_rsp.quot != '0);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// Digit stack: write on push, registered read of the top entry.
	always_ff @(posedge clk) begin
		if (push)
			stack_mem[cnt_q[rdc_pkg::STACK_AW-1:0]] <= div_rsp.rem;
		rd_q <= stack_mem[top[rdc_pkg::STACK_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			radix_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_take && (item.kind == rdc_pkg::KIND_CONV)) begin
						cnt_q   <= '0;
						radix_q <= item.radix;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (push)
							cnt_q <= cnt_q + 1'b1;
						if (div_rsp.quot == '0)
							state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						cnt_q   <= top;
						state_q <= (cnt_q == rdc_pkg::CNT_W'(1)) ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_bad || load_dig)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_bad) begin
			digit_q <= '0;
			last_q  <= 1'b1;
			bad_q   <= 1'b1;
		end else if (load_dig) begin
			digit_q <= rd_q;
			last_q  <= (cnt_q == rdc_pkg::CNT_W'(1));
			bad_q   <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign digit     = digit_q;
	assign last      = last_q;
	assign bad_radix = bad_q;

endmodule
